[hw/rtl/bridge_source_mac_learning_top_defines.svh]
// Assertion macros used by the checker file of the bridge source table.
`ifndef BRIDGE_SOURCE_MAC_LEARNING_TOP_DEFINES_SVH
`define BRIDGE_SOURCE_MAC_LEARNING_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSML_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsml: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BSML_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsml: next-cycle check failed");

`endif

[hw/rtl/bsml_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bsml_pkg;

    localparam int MAC_W = 48;

    typedef struct packed {
        logic             arrival_port;
        logic [MAC_W-1:0] source_mac;
    } t_in;

    typedef struct packed {
        logic forward;
        logic newly_learned;
        logic table_full;
    } t_out;

    // Head of the input queue as seen by the search engine.
    typedef struct packed {
        logic valid;
        t_in  item;
    } t_head;

endpackage

`default_nettype wire

[hw/rtl/bsml_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsml_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                        i_wr_data,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

[hw/rtl/bsml_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsml_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire bsml_pkg::t_in i_in_data,
    output bsml_pkg::t_head    o_head,
    input  wire logic          i_pop
);

    import bsml_pkg::*;

    // Two-entry queue between the input channel and the search engine.
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_wp;
    logic       n_rp;
    logic [1:0] n_cnt;
    t_in        r_q [2];
    logic       push;
    logic       pop;

    assign o_in_ready   = (r_cnt != 2'd2);
    assign push         = i_in_valid && o_in_ready;
    assign pop          = i_pop && (r_cnt != 2'd0);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp ^ push;
        n_rp  = r_rp ^ pop;
        n_cnt = r_cnt + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_in_data;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/bsml_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsml_back #(
    parameter int ENTRIES_PER_PORT = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire bsml_pkg::t_head i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output bsml_pkg::t_out       o_out_data
);

    import bsml_pkg::*;

    localparam int CNT_W = $clog2(ENTRIES_PER_PORT + 1);
    localparam int IDX_W = (ENTRIES_PER_PORT > 1) ? $clog2(ENTRIES_PER_PORT) : 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES_PER_PORT);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt0, n_cnt0;
    logic [CNT_W-1:0] r_cnt1, n_cnt1;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_pend_idx, n_pend_idx;
    logic             r_pend, n_pend;
    logic             r_hit0, n_hit0;
    logic             r_hit1, n_hit1;
    logic             r_out_valid, n_out_valid;
    t_out             r_out_data, n_out_data;
    t_in              r_item, n_item;

    logic [MAC_W-1:0] rd0;
    logic [MAC_W-1:0] rd1;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             we0;
    logic             we1;
    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] cnt_here;
    logic             issue;
    logic             match0;
    logic             match1;
    logic             hit_here;
    logic             hit_there;
    logic             fwd;
    logic             is_new;
    logic             learn;
    logic             out_free;
    logic             finish;

    // One table per arrival port; both are scanned at the same index.
    bsml_ram #(.WIDTH(MAC_W), .DEPTH(ENTRIES_PER_PORT)) u_ram0 (
        .i_clk     (i_clk),
        .i_we      (we0),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_item.source_mac),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd0)
    );

    bsml_ram #(.WIDTH(MAC_W), .DEPTH(ENTRIES_PER_PORT)) u_ram1 (
        .i_clk     (i_clk),
        .i_we      (we1),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_item.source_mac),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd1)
    );

    always_comb begin
        limit     = (r_cnt0 > r_cnt1) ? r_cnt0 : r_cnt1;
        issue     = (r_state == S_SCAN) && (r_idx < limit);
        rd_addr   = r_idx[IDX_W-1:0];
        match0    = r_pend && (r_pend_idx < r_cnt0) && (rd0 == r_item.source_mac);
        match1    = r_pend && (r_pend_idx < r_cnt1) && (rd1 == r_item.source_mac);
        cnt_here  = r_item.arrival_port ? r_cnt1 : r_cnt0;
        hit_here  = r_item.arrival_port ? r_hit1 : r_hit0;
        hit_there = r_item.arrival_port ? r_hit0 : r_hit1;
        fwd       = !hit_there;
        is_new    = fwd && !hit_here;
        learn     = is_new && (cnt_here != FULL_CNT);
        out_free  = !r_out_valid || i_out_ready;
        finish    = (r_state == S_DONE) && out_free;
        wr_addr   = cnt_here[IDX_W-1:0];
        we0       = finish && learn && !r_item.arrival_port;
        we1       = finish && learn && r_item.arrival_port;
        o_pop     = (r_state == S_IDLE) && i_head.valid;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt0      = r_cnt0;
        n_cnt1      = r_cnt1;
        n_idx       = r_idx;
        n_pend      = issue;
        n_pend_idx  = r_idx;
        n_hit0      = r_hit0 || match0;
        n_hit1      = r_hit1 || match1;
        n_item      = r_item;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;

        unique case (r_state)
            S_IDLE: begin
                n_pend = 1'b0;
                if (i_head.valid) begin
                    n_item  = i_head.item;
                    n_idx   = '0;
                    n_hit0  = 1'b0;
                    n_hit1  = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (issue) begin
                    n_idx = r_idx + 1'b1;
                end else begin
                    // Fold the last pending compare into the hits on the way out.
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid              = 1'b1;
                    n_out_data.forward       = fwd;
                    n_out_data.newly_learned = learn;
                    n_out_data.table_full    = is_new && !learn;
                    if (we0) begin
                        n_cnt0 = r_cnt0 + 1'b1;
                    end
                    if (we1) begin
                        n_cnt1 = r_cnt1 + 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt0      <= '0;
            r_cnt1      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt0      <= n_cnt0;
            r_cnt1      <= n_cnt1;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_pend_idx <= n_pend_idx;
        r_hit0     <= n_hit0;
        r_hit1     <= n_hit1;
        r_item     <= n_item;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

[hw/rtl/bridge_source_mac_learning_top.sv]
// Two-port bridge source-address table.
// Input channel (i_in_valid / o_in_ready / i_in_data): one item per received
// frame, carrying the arrival port (0 radio, 1 wired) and its 48-bit source MAC.
// Output channel (o_out_valid / i_out_ready / o_out_data): exactly one item per
// input item, in order: forward, newly_learned, table_full.
// A two-entry queue takes items while the search engine works. The engine
// scans both port tables side by side, one entry of each per cycle from a
// registered-read RAM, so the scan length is N = the larger of the two entry
// counts. Each item passes through the engine in steps: pop, N reads plus one
// final compare, finish.
// Reset (synchronous, active low) empties the queue and clears both entry
// counts; table contents are not cleared, as only entries below a count are
// ever compared. No clearing pass is needed.
// A stalled receiver holds the result in the output register; the engine
// waits in its finish step, while the queue keeps taking up to two items.
`timescale 1ns / 1ps
`default_nettype none

module bridge_source_mac_learning_top #(
    parameter int ENTRIES_PER_PORT = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire bsml_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output bsml_pkg::t_out      o_out_data
);

    import bsml_pkg::*;

    // Queue head handed to the engine, and the pop back from it.
    t_head head;
    logic  pop;

    // Front: accept items and hold them until the engine is free.
    bsml_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_head     (head),
        .i_pop      (pop)
    );

    // Back: search both tables, decide forward or drop, learn, post result.
    bsml_back #(.ENTRIES_PER_PORT(ENTRIES_PER_PORT)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

[hw/rtl/bsml_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "bridge_source_mac_learning_top_defines.svh"

module bsml_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_ready,
    input wire bsml_pkg::t_in  i_in_data,
    input wire logic           o_out_valid,
    input wire logic           i_out_ready,
    input wire bsml_pkg::t_out o_out_data
);

    import bsml_pkg::*;

    // Items accepted but not yet delivered; the design holds at most four.
    logic [2:0] r_open;
    logic       in_acc;
    logic       out_acc;
    logic       out_stall;
    logic       flags_ok;

    assign in_acc    = i_in_valid && o_in_ready;
    assign out_acc   = o_out_valid && i_out_ready;
    assign out_stall = o_out_valid && !i_out_ready;
    assign flags_ok  = (o_out_data.forward
                        || (!o_out_data.newly_learned && !o_out_data.table_full))
                       && !(o_out_data.newly_learned && o_out_data.table_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 3'd0;
        end else begin
            r_open <= r_open + 3'(in_acc) - 3'(out_acc);
        end
    end

    // Hold a stalled result.
    `BSML_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_out_data))

    // Never show a result without a pending item.
    `BSML_ASSERT_NOW(a_no_invented, i_clk, i_rst_n, o_out_valid, r_open != 3'd0)

    // Back-pressure only when items are in flight.
    `BSML_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, r_open == 3'd0, o_in_ready)

    // A dropped frame learns nothing; learning and full never go together.
    `BSML_ASSERT_NOW(a_flags_consistent, i_clk, i_rst_n, o_out_valid, flags_ok)

endmodule

bind bridge_source_mac_learning_top bsml_checker u_bsml_checker (.*);

`default_nettype wire
